// ===== sv/pfat_pkg.sv =====
`default_nettype none
package pfat_pkg;
    localparam int MaxFrames = 32;
    localparam int MaxProcs  = 8;
    localparam int FrW = $clog2(MaxFrames);
    localparam int PrW = $clog2(MaxProcs);
    localparam int FcW = $clog2(MaxFrames + 1);
    localparam int PtW = PrW + FrW;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0, ACT_XLATE = 2'd1, ACT_REPLACE = 2'd2, ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_BAD_SIZE = 4'd1, ST_FEW_FRAMES = 4'd2, ST_NO_SLOT = 4'd3,
        ST_UNKNOWN = 4'd4, ST_BAD_OFF = 4'd5, ST_UNMAPPED = 4'd6, ST_FAULT = 4'd7,
        ST_FAULT_REPL = 4'd8, ST_NO_PAGES = 4'd9, ST_NOT_FOUND = 4'd10,
        ST_NONE_FREE = 4'd11, ST_NOT_FREE = 4'd12, ST_NO_EXPAND = 4'd13,
        ST_BAD_KIND = 4'd14
    } t_status;

    localparam logic [1:0] CFG_PAGE_SIZE = 2'd0;
    localparam logic [1:0] CFG_INIT_FR   = 2'd1;
    localparam logic [1:0] CFG_FAULT_TH  = 2'd2;
    localparam logic [1:0] CFG_FAULT_LIM = 2'd3;

    // replace kinds; anything else is invalid
    localparam logic [1:0] RK_FREE   = 2'd0;
    localparam logic [1:0] RK_APPEND = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic scan_clr;  // clear scan counters
        logic scan_step; // one frame of the free scan
        logic div_step;  // one quotient bit
        logic alloc_step;// one frame of allocation
        logic pt_rd;     // page table read
        logic commit;    // decide and update state
        logic out_load;  // result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic alloc_done;
        logic need_scan;
        logic need_alloc;
        logic is_none;
        logic mul_busy;
    } t_sts;
endpackage
`default_nettype wire

// ===== sv/pfat_ctrl.sv =====
`default_nettype none
module pfat_ctrl
    import pfat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001, S_SCAN = 8'b0000_0010, S_DIV = 8'b0000_0100,
        S_ALLOC = 8'b0000_1000, S_PT = 8'b0001_0000, S_COMMIT = 8'b0010_0000,
        S_MUL = 8'b0100_0000, S_OUT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.is_none) begin
                    n_state = S_IDLE;
                end else if (i_sts.need_scan && !i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_sts.need_alloc) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_PT;
                end
            end
            S_ALLOC: begin
                if (!i_sts.alloc_done) begin
                    o_cmd.alloc_step = 1'b1;
                end else begin
                    n_state = S_PT;
                end
            end
            S_PT: begin
                o_cmd.pt_rd = 1'b1;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!i_sts.mul_busy && !(r_ovalid && i_stall)) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_out_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> r_state == S_MUL) else $error("result without commit");
endmodule
`default_nettype wire

// ===== sv/pfat_dp.sv =====
`default_nettype none
module pfat_dp
    import pfat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_proc_id,
    input  wire logic [15:0] i_process_bytes,
    input  wire logic [4:0]  i_logical_page,
    input  wire logic [15:0] i_byte_offset,
    input  wire logic [15:0] i_chance,
    input  wire logic [1:0]  i_replace_kind,
    input  wire logic [4:0]  i_target_frame,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    output logic [3:0]       o_status,
    output logic [2:0]       o_new_proc_id,
    output logic [20:0]      o_phys_addr,
    output logic [5:0]       o_pages_given,
    output logic [3:0]       o_faults_now,
    output logic [4:0]       o_frame_used
);
    // configuration
    logic [15:0] r_page_size;
    logic [16:0] r_fault_th;
    logic [3:0]  r_fault_lim;
    // state
    logic [PrW:0]    r_owner [MaxFrames]; // 0 free, else proc+1
    logic [FrW-1:0]  r_pt    [MaxProcs*MaxFrames];
    logic [FcW-1:0]  r_total [MaxProcs];
    logic [MaxProcs-1:0] r_exists;
    logic [PrW:0]    r_next;
    logic [3:0]      r_faults;
    logic [FcW-1:0]  r_active;
    // item
    logic [1:0]  r_act;
    logic [2:0]  r_proc;
    logic [15:0] r_bytes, r_off, r_chance;
    logic [4:0]  r_lp, r_tgt;
    logic [1:0]  r_kind;
    // scan / divide / alloc
    logic [FcW-1:0] r_idx, r_free, r_given;
    logic [16:0]    r_rem;
    logic [16:0]    r_quo;
    logic [4:0]     r_dcnt;
    logic           r_dstart;
    logic [FrW-1:0] r_ptq;
    logic [3:0]     r_st;
    logic [2:0]     r_nid;
    logic [5:0]     r_pg;
    logic [4:0]     r_fu;
    logic [31:0]    r_prod;
    logic [1:0]     r_mcnt;
    // decisions
    logic           rep_ok;
    logic [FrW-1:0] rep_frame;
    logic [3:0]     rep_st;
    logic [3:0]     pre_st;
    logic [FcW-1:0] tot;
    logic           id_ok_q;   // id was valid when the create committed

    logic [15:0] ps;
    logic [16:0] dividend;
    logic        id_ok;
    logic        create_ok;
    logic [FcW-1:0] idx_lim;
    assign ps = (r_page_size == '0) ? 16'd1 : r_page_size;
    assign dividend = {1'b0, r_bytes} + {1'b0, ps} - 17'd1;
    assign idx_lim = r_active;
    assign id_ok = r_next < (PrW+1)'(MaxProcs);
    assign create_ok = id_ok && r_bytes != '0 && r_quo <= 17'(r_free);

    assign o_sts.is_none   = r_act == ACT_NONE;
    assign o_sts.need_scan = r_act != ACT_XLATE;
    assign o_sts.scan_done = r_idx >= idx_lim;
    assign o_sts.div_done  = (r_act != ACT_CREATE) || (!r_dstart && r_dcnt == '0);
    assign o_sts.need_alloc = r_act == ACT_CREATE && create_ok;
    assign o_sts.alloc_done = r_given == FcW'(r_quo) || r_idx >= idx_lim;
    assign o_sts.mul_busy  = r_mcnt != '0;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= 16'd256;
            r_fault_th  <= 17'd65536;
            r_fault_lim <= 4'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_SIZE: r_page_size <= i_cfg_data[15:0];
                CFG_FAULT_TH:  r_fault_th  <= i_cfg_data;
                CFG_FAULT_LIM: r_fault_lim <= i_cfg_data[3:0];
                CFG_INIT_FR: ;
                default: ;
            endcase
        end
    end

    // page table memory
    logic [PtW-1:0] pt_waddr;
    logic           pt_we;
    logic [FrW-1:0] pt_wdata;
    always_comb begin
        pt_we = 1'b0;
        pt_waddr = {r_nid, r_given[FrW-1:0]};
        pt_wdata = r_idx[FrW-1:0];
        if (i_cmd.alloc_step && r_owner[r_idx[FrW-1:0]] == '0) pt_we = 1'b1;
        if (i_cmd.commit && r_act == ACT_REPLACE && pre_st == ST_OK && rep_ok) begin
            pt_we = 1'b1;
            pt_waddr = {r_proc, r_lp};
            pt_wdata = rep_frame;
        end
    end
    always_ff @(posedge i_clk) begin
        if (pt_we) r_pt[pt_waddr] <= pt_wdata;
        if (i_cmd.pt_rd) r_ptq <= r_pt[{r_proc, r_lp}];
    end

    // replace decision, evaluated at commit
    assign tot = r_total[r_proc];
    always_comb begin
        rep_ok = 1'b0;
        rep_frame = r_tgt;
        rep_st = ST_OK;
        if (tot == '0) rep_st = ST_NO_PAGES;
        else if (FcW'(r_lp) >= tot) rep_st = ST_NOT_FOUND;
        else if (r_kind == RK_FREE) begin
            if (r_free == '0) rep_st = ST_NONE_FREE;
            else if (FcW'(r_tgt) >= r_active || r_owner[r_tgt] != '0)
                rep_st = ST_NOT_FREE;
            else rep_ok = 1'b1;
        end else if (r_kind == RK_APPEND) begin
            if (r_active >= FcW'(MaxFrames)) rep_st = ST_NO_EXPAND;
            else begin
                rep_ok = 1'b1;
                rep_frame = r_active[FrW-1:0];
            end
        end else rep_st = ST_BAD_KIND;
    end
    always_comb begin
        pre_st = ST_OK;
        if (r_act == ACT_CREATE) begin
            if (!id_ok) pre_st = ST_NO_SLOT;
            else if (r_bytes == '0) pre_st = ST_BAD_SIZE;
            else if (!create_ok) pre_st = ST_FEW_FRAMES;
        end else if (!r_exists[r_proc]) pre_st = ST_UNKNOWN;
        else if (r_act == ACT_XLATE) begin
            if (r_off >= ps) pre_st = ST_BAD_OFF;
            else if (FcW'(r_lp) >= tot) pre_st = ST_UNMAPPED;
        end else pre_st = rep_st;
    end

    logic [3:0] finc;
    assign finc = r_faults + 4'd1;
    logic [3:0] flim;
    assign flim = (r_fault_lim == '0) ? 4'd1 : r_fault_lim;
    logic fault_hit;   // mapped translate that draws a fault
    logic xl_ok;       // mapped translate that yields an address
    assign fault_hit = r_act == ACT_XLATE && pre_st == ST_OK && 17'(r_chance) < r_fault_th;
    assign xl_ok = r_act == ACT_XLATE && pre_st == ST_OK && !fault_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < MaxFrames; f++) r_owner[f] <= '0;
            for (int p = 0; p < MaxProcs; p++) r_total[p] <= '0;
            r_exists <= '0;
            r_next   <= '0;
            r_faults <= '0;
            r_active <= FcW'(16);
            r_mcnt   <= '0;
            r_dstart <= 1'b0;
            r_dcnt   <= '0;
            r_free   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_INIT_FR && r_exists == '0) begin
                if (i_cfg_data[5:0] == '0) r_active <= FcW'(1);
                else if (i_cfg_data[5:0] > 6'(MaxFrames)) r_active <= FcW'(MaxFrames);
                else r_active <= FcW'(i_cfg_data[5:0]);
            end
            if (i_cmd.load) begin
                r_act <= i_action; r_proc <= i_proc_id; r_bytes <= i_process_bytes;
                r_lp <= i_logical_page; r_off <= i_byte_offset; r_chance <= i_chance;
                r_kind <= i_replace_kind; r_tgt <= i_target_frame;
                r_dstart <= 1'b1;
                r_nid <= r_next[PrW-1:0];
            end
            if (i_cmd.scan_clr) begin
                r_idx <= '0; r_given <= '0;
                if (i_cmd.load) r_free <= '0;
            end
            if (i_cmd.scan_step) begin
                if (r_owner[r_idx[FrW-1:0]] == '0) r_free <= r_free + FcW'(1);
                r_idx <= r_idx + FcW'(1);
            end
            // restoring divide, one quotient bit per cycle
            if (i_cmd.div_step) begin
                if (r_dstart) begin
                    r_dstart <= 1'b0;
                    r_dcnt <= 5'd17;
                    r_quo <= dividend;
                    r_rem <= '0;
                end else begin
                    logic [17:0] t;
                    t = {r_rem, r_quo[16]} - {2'b0, ps};
                    if (!t[17]) begin
                        r_rem <= t[16:0];
                        r_quo <= {r_quo[15:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[15:0], r_quo[16]};
                        r_quo <= {r_quo[15:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 5'd1;
                end
            end
            if (i_cmd.alloc_step) begin
                if (r_owner[r_idx[FrW-1:0]] == '0) begin
                    r_owner[r_idx[FrW-1:0]] <= {1'b0, r_nid} + (PrW+1)'(1);
                    r_given <= r_given + FcW'(1);
                end
                r_idx <= r_idx + FcW'(1);
            end
            if (i_cmd.commit) begin
                if (!fault_hit) r_st <= pre_st;
                else if (finc >= flim) r_st <= ST_FAULT_REPL;
                else r_st <= ST_FAULT;
                r_pg <= (r_act == ACT_CREATE && pre_st == ST_OK) ? 6'(r_given) : '0;
                r_fu <= (r_act == ACT_REPLACE && pre_st == ST_OK) ? rep_frame : '0;
                r_prod <= xl_ok ? 32'(r_ptq) * 32'(ps) : '0;
                if (r_act == ACT_CREATE) begin
                    if (id_ok) r_next <= r_next + (PrW+1)'(1);
                    if (pre_st == ST_OK) begin
                        r_total[r_nid] <= r_given;
                        r_exists[r_nid] <= 1'b1;
                    end
                end
                if (fault_hit) r_faults <= (finc >= flim) ? 4'd0 : finc;
                if (xl_ok) r_mcnt <= 2'd1;
                if (r_act == ACT_REPLACE && pre_st == ST_OK) begin
                    r_owner[r_ptq] <= '0;
                    r_owner[rep_frame] <= {1'b0, r_proc} + (PrW+1)'(1);
                    if (r_kind == RK_APPEND) r_active <= r_active + FcW'(1);
                end
            end
            if (r_mcnt != '0) begin
                r_prod <= r_prod + 32'(r_off);
                r_mcnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) id_ok_q <= id_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= r_st;
            o_new_proc_id <= (r_act == ACT_CREATE && id_ok_q) ? r_nid : '0;
            o_phys_addr   <= r_prod[20:0];
            o_pages_given <= r_pg;
            o_faults_now  <= r_faults;
            o_frame_used  <= r_fu;
        end
    end

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FcW'(MaxFrames)) else $error("free count overflow");
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= FcW'(MaxFrames) && r_active != '0) else $error("active frames out of range");
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= (PrW+1)'(MaxProcs)) else $error("process id overflow");
endmodule
`default_nettype wire

// ===== sv/paged_frame_allocator_translator.sv =====
// Paged frame allocator and address translator.
// Input channel: i_valid / o_stall carries one word holding action, process,
// size, page, offset, chance sample, replace kind and target frame.
// Output channel: o_valid / i_stall carries one result word per item
// (status, new id, physical address, pages given, fault count, frame used);
// action code 3 gives no result.
// One item at a time. Each item but a translate or action code 3 walks a
// free-frame scan; a create then runs a 17-bit restoring divide and, if it
// succeeds, an allocation sweep. Every item that gives a result then has a
// page-table read, a commit and, for translate, a multiply followed by an add.
// Configuration is a plain write port: i_cfg_we, i_cfg_idx, i_cfg_data.
// Reset (synchronous, low) frees all frames, clears processes and counters
// and loads the default register values; no clearing pass is needed.
// If the receiver stalls, the result is held in the output register; one
// more item may be taken in and worked up to its result, then input stalls.
`default_nettype none
module paged_frame_allocator_translator
    import pfat_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [2:0]  i_proc_id,
    input  wire logic [15:0] i_process_bytes,
    input  wire logic [4:0]  i_logical_page,
    input  wire logic [15:0] i_byte_offset,
    input  wire logic [15:0] i_chance,
    input  wire logic [1:0]  i_replace_kind,
    input  wire logic [4:0]  i_target_frame,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_status,
    output logic [2:0]       o_new_proc_id,
    output logic [20:0]      o_phys_addr,
    output logic [5:0]       o_pages_given,
    output logic [3:0]       o_faults_now,
    output logic [4:0]       o_frame_used
);
    t_cmd cmd;
    t_sts sts;

    pfat_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(sts), .o_cmd(cmd)
    );

    pfat_dp u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_action, .i_proc_id, .i_process_bytes, .i_logical_page,
        .i_byte_offset, .i_chance, .i_replace_kind, .i_target_frame,
        .i_cmd(cmd), .o_sts(sts),
        .o_status, .o_new_proc_id, .o_phys_addr, .o_pages_given,
        .o_faults_now, .o_frame_used
    );
endmodule
`default_nettype wire

// ===== tb/tb_paged_frame_allocator_translator.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_paged_frame_allocator_translator
    import pfat_pkg::*;
();

    // one input word, field by field
    typedef struct {
        t_action     act;
        logic [2:0]  pid;
        logic [15:0] bytes;
        logic [4:0]  lp;
        logic [15:0] off;
        logic [15:0] chance;
        logic [1:0]  kind;
        logic [4:0]  tgt;
    } t_word;

    // one result word
    typedef struct {
        t_status     st;
        logic [2:0]  nid;
        logic [20:0] addr;
        logic [5:0]  pages;
        logic [3:0]  faults;
        logic [4:0]  fused;
    } t_res;

    localparam int WatchdogLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [2:0]  i_proc_id = '0;
    logic [15:0] i_process_bytes = '0;
    logic [4:0]  i_logical_page = '0;
    logic [15:0] i_byte_offset = '0;
    logic [15:0] i_chance = '0;
    logic [1:0]  i_replace_kind = '0;
    logic [4:0]  i_target_frame = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_status;
    logic [2:0]  o_new_proc_id;
    logic [20:0] o_phys_addr;
    logic [5:0]  o_pages_given;
    logic [3:0]  o_faults_now;
    logic [4:0]  o_frame_used;

    paged_frame_allocator_translator dut (.*);

    always #5 i_clk = ~i_clk;

    // ---- mirror of the allocator state -----------------------------------
    logic [3:0]  owner [MaxFrames];          // 0 free, else proc + 1
    logic [5:0]  fmap [MaxProcs*MaxFrames];  // logical page -> frame
    logic [5:0]  ptotal [MaxProcs];
    logic        live [MaxProcs];
    int unsigned next_id, fault_cnt, act_frames;
    int unsigned pg_size, init_fr, thresh, flim;

    t_res results_due[$];   // results still owed by the block
    bit   failed;
    bit   no_idle;          // sender and receiver run flat out
    bit   hold_req;         // ask the receiver for one long hold-off

    function automatic int unsigned eff_page();
        return (pg_size == 0) ? 1 : pg_size;
    endfunction

    function automatic int unsigned free_frames();
        int unsigned n;
        n = 0;
        for (int f = 0; f < act_frames && f < MaxFrames; f++)
            if (owner[f] == 0) n++;
        return n;
    endfunction

    function automatic bit any_live();
        for (int p = 0; p < MaxProcs; p++)
            if (live[p]) return 1;
        return 0;
    endfunction

    function automatic t_word mk(t_action a, int pid, int bytes, int lp, int off,
                                 int chance, int kind, int tgt);
        t_word w;
        w.act = a; w.pid = 3'(pid); w.bytes = 16'(bytes); w.lp = 5'(lp);
        w.off = 16'(off); w.chance = 16'(chance); w.kind = 2'(kind); w.tgt = 5'(tgt);
        return w;
    endfunction

    // Work out the result of one accepted word and update the mirror.
    task automatic allocate_and_translate(input t_word w);
        t_res r;
        int unsigned ps, need, given, slot, old, nf, id;
        longint unsigned a;
        r.st = ST_OK; r.nid = '0; r.addr = '0; r.pages = '0; r.fused = '0;
        ps = eff_page();
        if (w.act == ACT_NONE) return;
        if (w.act == ACT_CREATE) begin
            if (next_id >= MaxProcs) begin
                r.st = ST_NO_SLOT;
            end else begin
                id = next_id;
                next_id++;
                r.nid = 3'(id);
                if (w.bytes == 0) begin
                    r.st = ST_BAD_SIZE;
                end else begin
                    need = (w.bytes + ps - 1) / ps;
                    if (need > free_frames()) begin
                        r.st = ST_FEW_FRAMES;
                    end else begin
                        given = 0;
                        for (int f = 0; f < act_frames && f < MaxFrames && given < need; f++) begin
                            if (owner[f] == 0) begin
                                owner[f] = 4'(id + 1);
                                fmap[id*MaxFrames + given] = 6'(f);
                                given++;
                            end
                        end
                        ptotal[id] = 6'(given);
                        live[id] = 1'b1;
                        r.pages = 6'(given);
                    end
                end
            end
        end else if (!live[w.pid]) begin
            r.st = ST_UNKNOWN;
        end else if (w.act == ACT_XLATE) begin
            if (w.off >= ps) begin
                r.st = ST_BAD_OFF;
            end else if (w.lp >= ptotal[w.pid]) begin
                r.st = ST_UNMAPPED;
            end else if (w.chance < thresh) begin
                fault_cnt = (fault_cnt + 1) & 4'hF;
                if (fault_cnt >= flim) begin
                    fault_cnt = 0;
                    r.st = ST_FAULT_REPL;
                end else begin
                    r.st = ST_FAULT;
                end
            end else begin
                a = longint'(fmap[w.pid*MaxFrames + w.lp]) * ps + w.off;
                r.addr = a[20:0];
            end
        end else begin
            if (ptotal[w.pid] == 0) begin
                r.st = ST_NO_PAGES;
            end else if (w.lp >= ptotal[w.pid]) begin
                r.st = ST_NOT_FOUND;
            end else begin
                slot = w.pid*MaxFrames + w.lp;
                old = fmap[slot] % MaxFrames;
                if (w.kind == RK_FREE) begin
                    if (free_frames() == 0) begin
                        r.st = ST_NONE_FREE;
                    end else if (w.tgt >= act_frames || owner[w.tgt] != 0) begin
                        r.st = ST_NOT_FREE;
                    end else begin
                        owner[old] = '0;
                        owner[w.tgt] = 4'(w.pid + 1);
                        fmap[slot] = {1'b0, w.tgt};
                        r.fused = w.tgt;
                    end
                end else if (w.kind == RK_APPEND) begin
                    if (act_frames >= MaxFrames) begin
                        r.st = ST_NO_EXPAND;
                    end else begin
                        nf = act_frames++;
                        owner[old] = '0;
                        owner[nf] = 4'(w.pid + 1);
                        fmap[slot] = 6'(nf);
                        r.fused = 5'(nf);
                    end
                end else begin
                    r.st = ST_BAD_KIND;
                end
            end
        end
        r.faults = 4'(fault_cnt);
        results_due = {results_due, r};
    endtask

    // ---- driving ----------------------------------------------------------
    task automatic send(input t_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_action <= w.act;
        i_proc_id <= w.pid;
        i_process_bytes <= w.bytes;
        i_logical_page <= w.lp;
        i_byte_offset <= w.off;
        i_chance <= w.chance;
        i_replace_kind <= w.kind;
        i_target_frame <= w.tgt;
        do @(posedge i_clk); while (o_stall);
        allocate_and_translate(w);
    endtask

    // drain the block before touching a register
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int unsigned data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[16:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            CFG_PAGE_SIZE: pg_size = data & 16'hFFFF;
            CFG_INIT_FR: begin
                init_fr = data & 6'h3F;
                if (!any_live())
                    act_frames = (init_fr == 0) ? 1 : (init_fr > MaxFrames) ? MaxFrames : init_fr;
            end
            CFG_FAULT_TH: thresh = data & 17'h1FFFF;
            CFG_FAULT_LIM: flim = data & 4'hF;
        endcase
    endtask

    // ---- receiver: random stalls, one long hold-off on request -------------
    initial begin
        int k;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                repeat (400) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            k = no_idle ? 0 : $urandom_range(0, 8);
            repeat (k) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // ---- result checker ---------------------------------------------------
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("result word with nothing expected, status %0d", o_status);
                failed = 1;
            end else begin
                e = results_due.pop_front();
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status); failed = 1;
                end
                if (o_new_proc_id !== e.nid) begin
                    $error("new_proc_id exp %0d got %0d", e.nid, o_new_proc_id); failed = 1;
                end
                if (o_phys_addr !== e.addr) begin
                    $error("phys_addr exp %0d got %0d", e.addr, o_phys_addr); failed = 1;
                end
                if (o_pages_given !== e.pages) begin
                    $error("pages_given exp %0d got %0d", e.pages, o_pages_given); failed = 1;
                end
                if (o_faults_now !== e.faults) begin
                    $error("faults_now exp %0d got %0d", e.faults, o_faults_now); failed = 1;
                end
                if (o_frame_used !== e.fused) begin
                    $error("frame_used exp %0d got %0d", e.fused, o_frame_used); failed = 1;
                end
            end
        end
    end

    // ---- watchdog: cycles with no word moving on either side ---------------
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("paged_frame_allocator_translator regression: fail");
                $finish;
            end
        end
    end

    // ---- tests --------------------------------------------------------------
    // frame count is only taken while no process exists: try both clamps
    task automatic test_frame_count();
        cfg_write(CFG_INIT_FR, 63);
        cfg_write(CFG_INIT_FR, 0);
        cfg_write(CFG_INIT_FR, 8);
        cfg_write(CFG_FAULT_TH, 0);
    endtask

    // id consumption on failure, ceiling page count, lowest free frames first
    task automatic test_create();
        send(mk(ACT_NONE, 0, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_XLATE, 7, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_REPLACE, 0, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 16'hFFFF, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 1, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 512, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 257, 0, 0, 0, 0, 0));
        wait_idle();
        cfg_write(CFG_INIT_FR, 20);    // processes exist: no effect
    endtask

    task automatic test_translate();
        send(mk(ACT_XLATE, 2, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_XLATE, 3, 0, 1, 255, 16'hFFFF, 0, 0));
        send(mk(ACT_XLATE, 3, 0, 1, 256, 0, 0, 0));
        send(mk(ACT_XLATE, 3, 0, 2, 0, 0, 0, 0));
        send(mk(ACT_XLATE, 3, 0, 31, 0, 0, 0, 0));
        send(mk(ACT_XLATE, 0, 0, 0, 0, 0, 0, 0));
        wait_idle();
        cfg_write(CFG_FAULT_TH, 65536);
        cfg_write(CFG_FAULT_LIM, 2);
        send(mk(ACT_XLATE, 2, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_XLATE, 2, 0, 0, 0, 16'hFFFF, 0, 0));
        wait_idle();
        cfg_write(CFG_FAULT_TH, 100);
        cfg_write(CFG_FAULT_LIM, 0);   // limit zero behaves as one
        send(mk(ACT_XLATE, 4, 0, 1, 7, 99, 0, 0));
        send(mk(ACT_XLATE, 4, 0, 1, 7, 100, 0, 0));
        wait_idle();
    endtask

    task automatic test_replace();
        send(mk(ACT_REPLACE, 3, 0, 0, 0, 0, 0, 5));
        send(mk(ACT_REPLACE, 3, 0, 0, 0, 0, 0, 0));
        send(mk(ACT_REPLACE, 3, 0, 0, 0, 0, 0, 31));
        send(mk(ACT_REPLACE, 3, 0, 0, 0, 0, 2, 0));
        send(mk(ACT_REPLACE, 3, 0, 0, 0, 0, 3, 0));
        send(mk(ACT_REPLACE, 3, 0, 5, 0, 0, 0, 0));
        send(mk(ACT_REPLACE, 3, 0, 1, 0, 0, 1, 0));
        // swallow every free frame, then nothing is left to move to
        send(mk(ACT_CREATE, 0, free_frames() * eff_page(), 0, 0, 0, 0, 0));
        send(mk(ACT_REPLACE, 2, 0, 0, 0, 0, 0, 0));
        // append up to the frame bound and one beyond
        repeat (MaxFrames - act_frames + 1)
            send(mk(ACT_REPLACE, 5, 0, 0, 0, 0, 1, 0));
        send(mk(ACT_CREATE, 0, 1, 0, 0, 0, 0, 0));
        send(mk(ACT_CREATE, 0, 1, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    function automatic t_word random_word();
        t_word w;
        int r, pid;
        w.act = t_action'($urandom_range(0, 3));
        w.pid = 3'($urandom); w.bytes = 16'($urandom); w.lp = 5'($urandom);
        w.off = 16'($urandom); w.chance = 16'($urandom); w.kind = 2'($urandom);
        w.tgt = 5'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10) return w;   // noise
        pid = $urandom_range(0, MaxProcs - 1);
        for (int n = 0; n < 16 && !live[pid]; n++)
            pid = $urandom_range(0, MaxProcs - 1);
        w.pid = 3'(pid);
        if (ptotal[pid] != 0) w.lp = 5'($urandom_range(0, ptotal[pid] - 1));
        if (r < 60) begin
            w.act = ACT_XLATE;
            w.off = 16'($urandom_range(0, eff_page() - 1));
        end else if (r < 97) begin
            w.act = ACT_REPLACE;
            w.kind = ($urandom_range(0, 9) < 7) ? RK_FREE : 2'($urandom_range(1, 3));
            if ($urandom_range(0, 1))
                for (int f = 0; f < act_frames; f++)
                    if (owner[f] == 0 && $urandom_range(0, 2) == 0) w.tgt = 5'(f);
        end else begin
            w.act = ACT_CREATE;
        end
        return w;
    endfunction

    task automatic test_random(input int unsigned ps, input int unsigned th,
                               input int unsigned lim, input int count);
        cfg_write(CFG_PAGE_SIZE, ps);
        cfg_write(CFG_FAULT_TH, th);
        cfg_write(CFG_FAULT_LIM, lim);
        repeat (count) send(random_word());
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < MaxFrames; i++) owner[i] = '0;
        for (int i = 0; i < MaxProcs*MaxFrames; i++) fmap[i] = '0;
        for (int i = 0; i < MaxProcs; i++) begin
            ptotal[i] = '0;
            live[i] = 1'b0;
        end
        next_id = 0; fault_cnt = 0;
        pg_size = 256; init_fr = 16; thresh = 65536; flim = 5; act_frames = 16;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_count();
        test_create();
        test_translate();
        test_replace();
        test_random(1, 0, 1, 230);
        hold_req = 1;            // receiver stops while the sender keeps offering
        test_random(65535, 65536, 15, 230);
        no_idle = 1;
        test_random(0, 30000, 3, 150);
        no_idle = 0;
        test_random($urandom_range(2, 4096), $urandom_range(0, 65536),
                    $urandom_range(0, 15), 230);
        test_random(256, 8000, 5, 230);
        repeat (200) @(posedge i_clk);

        if (failed)
            $display("paged_frame_allocator_translator regression: fail");
        else
            $display("paged_frame_allocator_translator regression: pass");
        $finish;
    end
endmodule
`default_nettype wire

// ===== paged_frame_allocator_translator.f =====
sv/pfat_pkg.sv
sv/pfat_ctrl.sv
sv/pfat_dp.sv
sv/paged_frame_allocator_translator.sv
tb/tb_paged_frame_allocator_translator.sv
